// File: hw/rtl/sgm_pkg.sv
// shared types and constants for the sgm path cost aggregation block
`timescale 1ns / 1ps
`default_nettype none
package sgm_pkg;

    localparam int COST_W     = 8;
    localparam int GRAY_W     = 8;
    localparam int P1_W       = 8;
    localparam int P2_W       = 12;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int DIV_W      = GRAY_W + 1;
    localparam int SUM_W      = P2_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [COST_W-1:0] COST_CAP = 8'hFF;

    localparam logic [P1_W-1:0]  SMALL_PENALTY_RST   = 8'd10;
    localparam logic [P2_W-1:0]  LARGE_PENALTY_RST   = 12'd150;
    localparam logic [CNT_W-1:0] DISPARITY_COUNT_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PENALTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_PENALTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_HERE,
        S_RD_BELOW,
        S_RD_ABOVE,
        S_CAP_ABOVE,
        S_DIV_WAIT,
        S_MIN,
        S_WRITE
    } t_state;

    typedef enum logic [1:0] {
        RD_HERE,
        RD_BELOW,
        RD_ABOVE
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        t_rd_sel rd_sel;
        logic    cap_here;
        logic    cap_below;
        logic    cap_above;
        logic    calc_best;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/sgm_path_cost_aggregation.sv
// top level of the sgm path cost aggregation block
// an accepted transaction goes through the read, divide, minimum and write-back states
// and no new transaction is taken until its result is written to the output register
// the pace is set by the 12-step restoring divider for the large penalty over gray step
// the three neighbor reads share the single read port of the cost ram, under the divider
// reset (synchronous, active low) restores the default registers and starts a new path
`timescale 1ns / 1ps
`default_nettype none
module sgm_path_cost_aggregation #(
    parameter int MAX_DISPARITIES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [sgm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [sgm_pkg::COST_W-1:0]     i_match_cost,
    input  wire logic [sgm_pkg::GRAY_W-1:0]     i_pixel_gray,
    input  wire logic                           i_path_start,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [sgm_pkg::COST_W-1:0]     o_path_cost,
    output logic      [sgm_pkg::IDX_W-1:0]      o_disparity_index,
    output logic                                o_pixel_done
);

    // one bank per pixel: write the current pixel, read the previous one
    localparam int AW        = $clog2(MAX_DISPARITIES) + 1;
    localparam int RAM_DEPTH = 2 ** AW;

    sgm_pkg::t_cmd    cmd;
    sgm_pkg::t_status status;

    logic                       div_load;
    logic [sgm_pkg::P2_W-1:0]   div_dividend;
    logic [sgm_pkg::DIV_W-1:0]  div_divisor;
    logic [sgm_pkg::P2_W-1:0]   div_quotient;
    logic                       div_done;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [sgm_pkg::COST_W-1:0] ram_wdata;
    logic [sgm_pkg::COST_W-1:0] ram_rdata;

    // sequencing
    sgm_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic, path state and output register
    sgm_datapath #(
        .MAX_DISPARITIES (MAX_DISPARITIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_match_cost      (i_match_cost),
        .i_pixel_gray      (i_pixel_gray),
        .i_path_start      (i_path_start),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_div_load        (div_load),
        .o_div_dividend    (div_dividend),
        .o_div_divisor     (div_divisor),
        .i_div_quotient    (div_quotient),
        .i_div_done        (div_done),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_path_cost       (o_path_cost),
        .o_disparity_index (o_disparity_index),
        .o_pixel_done      (o_pixel_done)
    );

    // large penalty over gray step plus one, started at accept
    sgm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_done     (div_done)
    );

    // previous and current aggregated costs, ping-pong banks
    sgm_ram #(
        .WIDTH (sgm_pkg::COST_W),
        .DEPTH (RAM_DEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction is in flight");

    // write-back only when the output register can take the result
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> status.out_free)
        else $error("write-back while output register is full");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("result lost after write-back");

    // best cost uses a finished quotient
    a_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.calc_best |-> div_done)
        else $error("minimum taken before division finished");

endmodule
`default_nettype wire

// File: hw/rtl/sgm_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/sgm_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sgm_divider (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [sgm_pkg::P2_W-1:0]  i_dividend,
    input  wire logic [sgm_pkg::DIV_W-1:0] i_divisor,
    output logic      [sgm_pkg::P2_W-1:0]  o_quotient,
    output logic                           o_done
);

    localparam int STEP_W = $clog2(sgm_pkg::P2_W + 1);

    logic [sgm_pkg::P2_W-1:0]  r_quo;
    logic [sgm_pkg::DIV_W-1:0] r_rem;
    logic [sgm_pkg::DIV_W-1:0] r_div;
    logic [STEP_W-1:0]         r_cnt;
    logic                      r_busy;
    logic [sgm_pkg::DIV_W:0]   shifted;
    logic [sgm_pkg::DIV_W:0]   trial;

    assign shifted = {r_rem, r_quo[sgm_pkg::P2_W-1]};
    assign trial   = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(sgm_pkg::P2_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_busy <= (r_cnt != STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                r_rem <= trial[sgm_pkg::DIV_W-1:0];
                r_quo <= {r_quo[sgm_pkg::P2_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[sgm_pkg::DIV_W-1:0];
                r_quo <= {r_quo[sgm_pkg::P2_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = !r_busy;

endmodule
`default_nettype wire

// File: hw/rtl/sgm_datapath.sv
// datapath: config registers, path state, cost arithmetic and output register
`timescale 1ns / 1ps
`default_nettype none
module sgm_datapath #(
    parameter int MAX_DISPARITIES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sgm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [sgm_pkg::COST_W-1:0]       i_match_cost,
    input  wire logic [sgm_pkg::GRAY_W-1:0]       i_pixel_gray,
    input  wire logic                             i_path_start,
    input  wire sgm_pkg::t_cmd                    i_cmd,
    output sgm_pkg::t_status                      o_status,
    output logic                                  o_div_load,
    output logic      [sgm_pkg::P2_W-1:0]         o_div_dividend,
    output logic      [sgm_pkg::DIV_W-1:0]        o_div_divisor,
    input  wire logic [sgm_pkg::P2_W-1:0]         i_div_quotient,
    input  wire logic                             i_div_done,
    output logic                                  o_ram_we,
    output logic      [$clog2(MAX_DISPARITIES):0] o_ram_waddr,
    output logic      [sgm_pkg::COST_W-1:0]       o_ram_wdata,
    output logic      [$clog2(MAX_DISPARITIES):0] o_ram_raddr,
    input  wire logic [sgm_pkg::COST_W-1:0]       i_ram_rdata,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [sgm_pkg::COST_W-1:0]       o_path_cost,
    output logic      [sgm_pkg::IDX_W-1:0]        o_disparity_index,
    output logic                                  o_pixel_done
);

    localparam int DW    = $clog2(MAX_DISPARITIES);
    localparam int CMP_W = $clog2(MAX_DISPARITIES + 1) + sgm_pkg::CNT_W;
    localparam int XW    = DW + sgm_pkg::IDX_W;

    // config
    logic [sgm_pkg::P1_W-1:0]  r_small_penalty;
    logic [sgm_pkg::P2_W-1:0]  r_large_penalty;
    logic [sgm_pkg::CNT_W-1:0] r_disparity_count;

    // path state
    logic [DW-1:0]             r_d;
    logic                      r_fpa;
    logic                      r_bank;
    logic [sgm_pkg::COST_W-1:0] r_pm;
    logic [sgm_pkg::COST_W-1:0] r_rmin;
    logic [sgm_pkg::GRAY_W-1:0] r_last_gray;
    logic                      r_out_valid;

    // item payload
    logic [sgm_pkg::COST_W-1:0] r_cost;
    logic [sgm_pkg::GRAY_W-1:0] r_gray;
    logic [sgm_pkg::COST_W-1:0] r_here;
    logic [sgm_pkg::COST_W-1:0] r_below;
    logic [sgm_pkg::COST_W-1:0] r_above;
    logic [sgm_pkg::COST_W-1:0] r_best;
    logic [sgm_pkg::COST_W-1:0] r_path_cost;
    logic [sgm_pkg::IDX_W-1:0]  r_disparity_index;
    logic                       r_pixel_done;

    logic [CMP_W-1:0]           dc_ext;
    logic [CMP_W-1:0]           eff_count;
    logic [CMP_W-1:0]           d_next_ext;
    logic                       at_last;
    logic [sgm_pkg::GRAY_W-1:0] gray_diff;
    logic [DW-1:0]              rd_d;
    logic [sgm_pkg::P1_W:0]     near_lo;
    logic [sgm_pkg::P1_W:0]     near_hi;
    logic [sgm_pkg::P2_W-1:0]   jump;
    logic [sgm_pkg::SUM_W-1:0]  far;
    logic [sgm_pkg::SUM_W-1:0]  min_a;
    logic [sgm_pkg::SUM_W-1:0]  min_b;
    logic [sgm_pkg::SUM_W-1:0]  best;
    logic [sgm_pkg::COST_W-1:0] result;
    logic [sgm_pkg::COST_W-1:0] rmin_new;
    logic [XW-1:0]              d_wide;

    // effective disparity count, zero taken as one, saturated to the maximum
    assign dc_ext = CMP_W'(r_disparity_count);
    always_comb begin
        if (r_disparity_count == '0) begin
            eff_count = CMP_W'(1);
        end else if (dc_ext > CMP_W'(MAX_DISPARITIES)) begin
            eff_count = CMP_W'(MAX_DISPARITIES);
        end else begin
            eff_count = dc_ext;
        end
    end
    assign d_next_ext = CMP_W'(r_d) + CMP_W'(1);
    assign at_last    = (d_next_ext >= eff_count);

    // divider gets the gray step of the incoming transaction
    assign gray_diff = (i_pixel_gray > r_last_gray) ? (i_pixel_gray - r_last_gray)
                                                    : (r_last_gray - i_pixel_gray);
    assign o_div_load     = i_cmd.accept;
    assign o_div_dividend = r_large_penalty;
    assign o_div_divisor  = {1'b0, gray_diff} + sgm_pkg::DIV_W'(1);

    // previous pixel lives in the other bank
    always_comb begin
        case (i_cmd.rd_sel)
            sgm_pkg::RD_HERE:  rd_d = r_d;
            sgm_pkg::RD_BELOW: rd_d = r_d - DW'(1);
            sgm_pkg::RD_ABOVE: rd_d = r_d + DW'(1);
            default:           rd_d = r_d;
        endcase
    end
    assign o_ram_raddr = {~r_bank, rd_d};
    assign o_ram_waddr = {r_bank, r_d};
    assign o_ram_wdata = result;
    assign o_ram_we    = i_cmd.commit;

    // penalty terms
    assign near_lo = {1'b0, r_below} + {1'b0, r_small_penalty};
    assign near_hi = {1'b0, r_above} + {1'b0, r_small_penalty};
    assign jump    = (i_div_quotient < sgm_pkg::P2_W'(r_small_penalty))
                   ? sgm_pkg::P2_W'(r_small_penalty) : i_div_quotient;
    assign far     = sgm_pkg::SUM_W'(r_pm) + sgm_pkg::SUM_W'(jump);
    assign min_a   = (sgm_pkg::SUM_W'(r_here) < sgm_pkg::SUM_W'(near_lo))
                   ? sgm_pkg::SUM_W'(r_here) : sgm_pkg::SUM_W'(near_lo);
    assign min_b   = (sgm_pkg::SUM_W'(near_hi) < far) ? sgm_pkg::SUM_W'(near_hi) : far;
    assign best    = (min_a < min_b) ? min_a : min_b;

    assign result   = r_fpa ? r_cost : (r_cost + r_best - r_pm);
    assign rmin_new = (result < r_rmin) ? result : r_rmin;
    assign d_wide   = XW'(r_d);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_penalty   <= sgm_pkg::SMALL_PENALTY_RST;
            r_large_penalty   <= sgm_pkg::LARGE_PENALTY_RST;
            r_disparity_count <= sgm_pkg::DISPARITY_COUNT_RST;
            r_d               <= '0;
            r_fpa             <= 1'b1;
            r_bank            <= 1'b0;
            r_pm              <= sgm_pkg::COST_CAP;
            r_rmin            <= sgm_pkg::COST_CAP;
            r_last_gray       <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgm_pkg::CFG_SMALL_PENALTY:
                        r_small_penalty <= i_cfg_data[sgm_pkg::P1_W-1:0];
                    sgm_pkg::CFG_LARGE_PENALTY:
                        r_large_penalty <= i_cfg_data[sgm_pkg::P2_W-1:0];
                    sgm_pkg::CFG_DISPARITY_COUNT:
                        r_disparity_count <= i_cfg_data[sgm_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            // path start counts only on disparity zero
            if (i_cmd.accept && (r_d == '0) && i_path_start) begin
                r_fpa <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (at_last) begin
                    r_bank      <= ~r_bank;
                    r_pm        <= rmin_new;
                    r_rmin      <= sgm_pkg::COST_CAP;
                    r_last_gray <= r_gray;
                    r_d         <= '0;
                    r_fpa       <= 1'b0;
                end else begin
                    r_rmin <= rmin_new;
                    r_d    <= r_d + DW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cost <= i_match_cost;
            r_gray <= i_pixel_gray;
        end
        if (i_cmd.cap_here) begin
            r_here <= i_ram_rdata;
        end
        if (i_cmd.cap_below) begin
            r_below <= (r_d == '0) ? sgm_pkg::COST_CAP : i_ram_rdata;
        end
        if (i_cmd.cap_above) begin
            r_above <= at_last ? sgm_pkg::COST_CAP : i_ram_rdata;
        end
        // best never exceeds the cost at d, so it fits in eight bits
        if (i_cmd.calc_best) begin
            r_best <= best[sgm_pkg::COST_W-1:0];
        end
        if (i_cmd.commit) begin
            r_path_cost       <= result;
            r_disparity_index <= d_wide[sgm_pkg::IDX_W-1:0];
            r_pixel_done      <= at_last;
        end
    end

    assign o_status.div_done = i_div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_path_cost       = r_path_cost;
    assign o_disparity_index = r_disparity_index;
    assign o_pixel_done      = r_pixel_done;

endmodule
`default_nettype wire

// File: hw/rtl/sgm_controller.sv
// controller state machine sequencing reads, division and write-back
`timescale 1ns / 1ps
`default_nettype none
module sgm_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire sgm_pkg::t_status i_status,
    output sgm_pkg::t_cmd         o_cmd
);

    sgm_pkg::t_state r_state;
    sgm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sgm_pkg::S_IDLE:      if (i_in_valid) n_state = sgm_pkg::S_RD_HERE;
            sgm_pkg::S_RD_HERE:   n_state = sgm_pkg::S_RD_BELOW;
            sgm_pkg::S_RD_BELOW:  n_state = sgm_pkg::S_RD_ABOVE;
            sgm_pkg::S_RD_ABOVE:  n_state = sgm_pkg::S_CAP_ABOVE;
            sgm_pkg::S_CAP_ABOVE: n_state = sgm_pkg::S_DIV_WAIT;
            sgm_pkg::S_DIV_WAIT:  if (i_status.div_done) n_state = sgm_pkg::S_MIN;
            sgm_pkg::S_MIN:       n_state = sgm_pkg::S_WRITE;
            sgm_pkg::S_WRITE:     if (i_status.out_free) n_state = sgm_pkg::S_IDLE;
            default:              n_state = sgm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = sgm_pkg::RD_HERE;
        o_in_stall   = 1'b1;
        case (r_state)
            sgm_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            sgm_pkg::S_RD_HERE: begin
                o_cmd.rd_sel = sgm_pkg::RD_HERE;
            end
            sgm_pkg::S_RD_BELOW: begin
                o_cmd.rd_sel   = sgm_pkg::RD_BELOW;
                o_cmd.cap_here = 1'b1;
            end
            sgm_pkg::S_RD_ABOVE: begin
                o_cmd.rd_sel    = sgm_pkg::RD_ABOVE;
                o_cmd.cap_below = 1'b1;
            end
            sgm_pkg::S_CAP_ABOVE: begin
                o_cmd.cap_above = 1'b1;
            end
            sgm_pkg::S_DIV_WAIT: ;
            sgm_pkg::S_MIN: begin
                o_cmd.calc_best = 1'b1;
            end
            sgm_pkg::S_WRITE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: verif/tb_sgm_path_cost_aggregation.sv
// testbench for sgm_path_cost_aggregation: directed and random path streams against a predictor
`timescale 1ns / 1ps
module tb_sgm_path_cost_aggregation;

    localparam int DISP_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 400000;

    // one aggregated cost as it leaves the block
    typedef struct {
        logic [sgm_pkg::COST_W-1:0] cost;
        logic [sgm_pkg::IDX_W-1:0]  idx;
        logic                       done;
    } t_path_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [sgm_pkg::CFG_IDX_W-1:0]  i_cfg_index = sgm_pkg::CFG_SMALL_PENALTY;
    logic [sgm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [sgm_pkg::COST_W-1:0]     i_match_cost = '0;
    logic [sgm_pkg::GRAY_W-1:0]     i_pixel_gray = '0;
    logic                           i_path_start = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [sgm_pkg::COST_W-1:0]     o_path_cost;
    logic [sgm_pkg::IDX_W-1:0]      o_disparity_index;
    logic                           o_pixel_done;

    sgm_path_cost_aggregation #(.MAX_DISPARITIES(DISP_DEPTH)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_match_cost      (i_match_cost),
        .i_pixel_gray      (i_pixel_gray),
        .i_path_start      (i_path_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_path_cost       (o_path_cost),
        .o_disparity_index (o_disparity_index),
        .o_pixel_done      (o_pixel_done)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the configuration, reset values
    logic [sgm_pkg::P1_W-1:0]  small_pen = sgm_pkg::SMALL_PENALTY_RST;
    logic [sgm_pkg::P2_W-1:0]  large_pen = sgm_pkg::LARGE_PENALTY_RST;
    logic [sgm_pkg::CNT_W-1:0] disp_count = sgm_pkg::DISPARITY_COUNT_RST;

    // predictor copy of the path state
    logic [sgm_pkg::COST_W-1:0] prev_cost [DISP_DEPTH];
    logic [sgm_pkg::COST_W-1:0] cur_cost [DISP_DEPTH];
    logic [sgm_pkg::COST_W-1:0] prev_min = sgm_pkg::COST_CAP;
    logic [sgm_pkg::COST_W-1:0] run_min = sgm_pkg::COST_CAP;
    logic [sgm_pkg::GRAY_W-1:0] last_gray = '0;
    int unsigned       disp_ctr = 0;
    bit                first_active = 1'b1;
    // entries of the previous pixel that were actually written
    int unsigned       prev_span = 0;

    t_path_result pending_costs[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;    // no idling on either side in the closing phase
    bit           gaps_on = 1'b1;  // sender gaps allowed in the current phase
    int           stall_left = 0;
    int           calm_left = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // count of disparities per pixel that the block actually uses
    function automatic int unsigned active_count();
        if (disp_count == 0) return 1;
        if (disp_count > DISP_DEPTH) return DISP_DEPTH;
        return 32'(disp_count);
    endfunction

    // path cost update for one accepted transaction, queues the expected result
    task automatic aggregate_cost(input logic [sgm_pkg::COST_W-1:0] cost,
                                  input logic [sgm_pkg::GRAY_W-1:0] gray,
                                  input logic start);
        int unsigned  n, d, p1, pm, cap, g, lg, here, below, above, diff, jump, best, res;
        t_path_result r;
        n   = active_count();
        d   = disp_ctr;
        p1  = 32'(small_pen);
        pm  = 32'(prev_min);
        cap = 32'(sgm_pkg::COST_CAP);
        g   = 32'(gray);
        lg  = 32'(last_gray);
        if (d >= DISP_DEPTH) d = DISP_DEPTH - 1;
        // path start only counts on disparity 0
        if (d == 0 && start) first_active = 1'b1;
        if (first_active) begin
            res = 32'(cost);
        end else begin
            here  = 32'(prev_cost[d]);
            below = (d == 0) ? cap : 32'(prev_cost[d - 1]);
            above = (d + 1 >= n) ? cap : 32'(prev_cost[d + 1]);
            diff  = (g > lg) ? g - lg : lg - g;
            jump  = 32'(large_pen) / (diff + 1);
            if (jump < p1) jump = p1;
            best = here;
            if (below + p1 < best) best = below + p1;
            if (above + p1 < best) best = above + p1;
            if (pm + jump < best) best = pm + jump;
            // difference and sum both wrap to 8 bits
            res = (32'(cost) + ((best - pm) & 32'hFF)) & 32'hFF;
        end
        cur_cost[d] = res[sgm_pkg::COST_W-1:0];
        if (res[sgm_pkg::COST_W-1:0] < run_min) run_min = res[sgm_pkg::COST_W-1:0];
        r.cost = res[sgm_pkg::COST_W-1:0];
        r.idx  = d[sgm_pkg::IDX_W-1:0];
        r.done = (d + 1 >= n);
        pending_costs = {pending_costs, r};
        if (r.done) begin
            prev_cost    = cur_cost;
            prev_min     = run_min;
            run_min      = sgm_pkg::COST_CAP;
            last_gray    = gray;
            disp_ctr     = 0;
            first_active = 1'b0;
            prev_span    = d + 1;
        end else begin
            disp_ctr = d + 1;
        end
    endtask

    // one cost transaction; returns at the edge that accepted it
    task automatic send_cost(input logic [sgm_pkg::COST_W-1:0] cost,
                             input logic [sgm_pkg::GRAY_W-1:0] gray,
                             input logic start);
        logic start_eff;
        start_eff = start;
        // a pixel wider than its predecessor would read unwritten entries: start a new path
        if (disp_ctr == 0 && !first_active && active_count() > prev_span) start_eff = 1'b1;
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_match_cost <= cost;
        i_pixel_gray <= gray;
        i_path_start <= start_eff;
        do @(posedge i_clk); while (o_in_stall);
        aggregate_cost(cost, gray, start_eff);
    endtask

    // hold the sender until every queued result has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // writes all three registers on consecutive cycles, block must be idle
    task automatic set_regs(input logic [sgm_pkg::P1_W-1:0] p1,
                            input logic [sgm_pkg::P2_W-1:0] p2,
                            input logic [sgm_pkg::CNT_W-1:0] cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sgm_pkg::CFG_SMALL_PENALTY;
        i_cfg_data  <= sgm_pkg::CFG_DATA_W'(p1);
        @(posedge i_clk);
        i_cfg_index <= sgm_pkg::CFG_LARGE_PENALTY;
        i_cfg_data  <= sgm_pkg::CFG_DATA_W'(p2);
        @(posedge i_clk);
        i_cfg_index <= sgm_pkg::CFG_DISPARITY_COUNT;
        i_cfg_data  <= sgm_pkg::CFG_DATA_W'(cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        small_pen  = p1;
        large_pen  = p2;
        disp_count = cnt;
    endtask

    // pass-through after reset, then a shrink that ends the pixel early
    task automatic test_reset_and_shrink();
        send_cost(8'd37, 8'd200, 1'b0);
        send_cost(8'd255, 8'd9, 1'b1);
        wait_drained();
        set_regs(8'd10, 12'd150, 7'd2);
        send_cost(8'd14, 8'd90, 1'b0);
        // first pixel on the shrunken count, reads entries the short pixel wrote
        send_cost(8'd0, 8'd0, 1'b0);
        send_cost(8'd255, 8'd0, 1'b0);
    endtask

    task automatic test_penalty_extremes();
        wait_drained();
        set_regs(8'd255, 12'd4095, 7'd3);
        send_cost(8'd255, 8'd255, 1'b0);
        send_cost(8'd0, 8'd255, 1'b0);
        send_cost(8'd255, 8'd255, 1'b0);
        // full gray step
        send_cost(8'd0, 8'd0, 1'b0);
        send_cost(8'd255, 8'd0, 1'b0);
        send_cost(8'd128, 8'd0, 1'b0);
        // no gray step: large penalty undivided
        send_cost(8'd200, 8'd0, 1'b0);
        send_cost(8'd1, 8'd0, 1'b0);
        send_cost(8'd77, 8'd0, 1'b0);
        wait_drained();
        set_regs(8'd0, 12'd0, 7'd3);
        send_cost(8'd255, 8'd128, 1'b0);
        send_cost(8'd255, 8'd128, 1'b0);
        send_cost(8'd0, 8'd127, 1'b0);
    endtask

    // a count of zero behaves as one disparity per pixel
    task automatic test_count_limits();
        wait_drained();
        set_regs(8'd3, 12'd4095, 7'd0);
        send_cost(8'd170, 8'd0, 1'b0);
        send_cost(8'd85, 8'd255, 1'b0);
    endtask

    // start flag restarts on disparity 0 and is ignored later in the pixel
    task automatic test_path_start();
        wait_drained();
        set_regs(8'd10, 12'd150, 7'd2);
        send_cost(8'd5, 8'd40, 1'b1);
        send_cost(8'd6, 8'd40, 1'b0);
        send_cost(8'd90, 8'd60, 1'b0);
        send_cost(8'd3, 8'd61, 1'b1);
    endtask

    // whole pixels with random content until about n transactions have gone in
    task automatic run_pixels(input int n);
        int          sent;
        int unsigned cnt;
        logic [7:0]  gray;
        logic [7:0]  cost;
        bit          own_gray;
        sent = 0;
        while (sent < n) begin
            cnt = active_count();
            case ($urandom_range(0, 5))
                0:       gray = 8'd0;
                1:       gray = 8'd255;
                2:       gray = last_gray;
                default: gray = 8'($urandom_range(0, 255));
            endcase
            own_gray = ($urandom_range(0, 9) == 0);
            for (int d = 0; d < cnt; d++) begin
                case ($urandom_range(0, 7))
                    0:       cost = 8'd0;
                    1:       cost = 8'd255;
                    default: cost = 8'($urandom_range(0, 255));
                endcase
                send_cost(cost, own_gray ? 8'($urandom_range(0, 255)) : gray,
                          (d == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 7) == 0));
            end
            sent += cnt;
            // occasional full stop of the sender
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
    endtask

    task automatic test_random_paths();
        logic [sgm_pkg::P1_W-1:0]  p1;
        logic [sgm_pkg::P2_W-1:0]  p2;
        logic [sgm_pkg::CNT_W-1:0] cnt;
        for (int phase = 0; phase < 8; phase++) begin
            p1  = 8'($urandom_range(0, 255));
            p2  = 12'($urandom_range(0, 4095));
            cnt = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 10));
            case (phase)
                0: begin p1 = 8'd255; p2 = 12'd4095; cnt = 7'd127; end
                1: begin p1 = 8'd0;   p2 = 12'd0;    cnt = 7'd1;   end
                2: begin
                    p1  = sgm_pkg::SMALL_PENALTY_RST;
                    p2  = sgm_pkg::LARGE_PENALTY_RST;
                    cnt = 7'd4;
                end
                default: ;
            endcase
            gaps_on = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            if (phase == 7) quiet = 1'b1;
            wait_drained();
            set_regs(p1, p2, cnt);
            run_pixels((phase == 0) ? 128 : (phase == 1) ? 40 : 75);
        end
    endtask

    // output side stall bursts with calm stretches in between
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
        end else if (calm_left != 0 || quiet) begin
            calm_left   <= (calm_left != 0) ? calm_left - 1 : 0;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 39) == 0) calm_left <= $urandom_range(30, 120);
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_path_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_costs.size() == 0) begin
                flag_mismatch($sformatf("unexpected result cost %0d index %0d",
                                        o_path_cost, o_disparity_index));
            end else begin
                want = pending_costs.pop_front();
                if (o_path_cost !== want.cost)
                    flag_mismatch($sformatf("path_cost %0d, want %0d at index %0d",
                                            o_path_cost, want.cost, want.idx));
                if (o_disparity_index !== want.idx)
                    flag_mismatch($sformatf("disparity_index %0d, want %0d",
                                            o_disparity_index, want.idx));
                if (o_pixel_done !== want.done)
                    flag_mismatch($sformatf("pixel_done %0b, want %0b at index %0d",
                                            o_pixel_done, want.done, want.idx));
            end
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sgm_path_cost_aggregation: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_and_shrink();
        test_penalty_extremes();
        test_count_limits();
        test_path_start();
        test_random_paths();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_sgm_path_cost_aggregation: done, clean");
        else
            $display("tb_sgm_path_cost_aggregation: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_ram.sv
hw/rtl/sgm_divider.sv
hw/rtl/sgm_datapath.sv
hw/rtl/sgm_controller.sv
hw/rtl/sgm_path_cost_aggregation.sv
verif/tb_sgm_path_cost_aggregation.sv
